@@ hdl/psl_pkg.sv @@
// Shared types and codes for the priority stack core.
// Used by psl_cell and priority_stack_lifo_ties_core; no dependencies.
package psl_pkg;

    // Field widths of the request and result items
    localparam int OP_W     = 2;
    localparam int PRIO_W   = 8;
    localparam int VAL_W    = 32;
    localparam int STATUS_W = 2;
    localparam int CNT_W    = 5;

    // Packed stream widths, rounded up to whole bytes
    localparam int IN_BITS  = OP_W + PRIO_W + VAL_W;
    localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS = STATUS_W + VAL_W + CNT_W + 1;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    // Operation codes
    localparam logic [OP_W-1:0] OP_PUSH  = 2'd0;
    localparam logic [OP_W-1:0] OP_POP   = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // One held entry, as passed between neighbouring cells
    typedef struct packed {
        logic                    valid;
        logic [PRIO_W-1:0]       prio;
        logic signed [VAL_W-1:0] value;
    } t_entry;

    // Broadcast command to every cell of the chain
    typedef struct packed {
        logic                    push;
        logic                    pop;
        logic                    clear;
        logic [PRIO_W-1:0]       prio;
        logic signed [VAL_W-1:0] value;
    } t_cell_ctrl;

endpackage

@@ hdl/priority_stack_lifo_ties_core.sv @@
// Bounded priority stack built as a sorted chain of psl_cell slots.
// Depends on psl_pkg and psl_cell.
//
// Usage:
//   Requests enter on the slave stream (i_s_tvalid / o_s_tready / i_s_tdata):
//   push a priority and value, pop the highest priority entry (newest among
//   equal priorities), or clear. Each request gives exactly one result on the
//   master stream (o_m_tvalid / i_m_tready / o_m_tdata) carrying the status,
//   the popped value, the entry count and an empty flag.
//   The result is registered and appears in the cycle after acceptance.
//   Throughput: one request per cycle while the receiver takes results.
//   The chain is kept sorted, highest priority at cell 0, so a push is a
//   parallel compare-and-shift and a pop reads cell 0 and shifts it left.
//   Reset (i_rst_n low, synchronous) empties the store and drops any result
//   not yet taken.
//   When the receiver stalls, the result stays in the output register and
//   o_s_tready falls until it is taken; no request is lost.
module priority_stack_lifo_ties_core #(
    parameter int DEPTH = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s_tvalid,
    output logic                       o_s_tready,
    // [1:0] op, [9:2] priority_req, [41:10] value, [47:42] zero
    input  logic [psl_pkg::IN_W-1:0]   i_s_tdata,
    output logic                       o_m_tvalid,
    input  logic                       i_m_tready,
    // [1:0] status, [33:2] popped_value, [38:34] entry_count, [39] is_empty
    output logic [psl_pkg::OUT_W-1:0]  o_m_tdata
);

    localparam int CW = $clog2(DEPTH + 1);

    // Request fields
    logic [psl_pkg::OP_W-1:0]           req_op;
    logic [psl_pkg::PRIO_W-1:0]         req_prio;
    logic signed [psl_pkg::VAL_W-1:0]   req_value;
    assign req_op    = i_s_tdata[psl_pkg::OP_W-1:0];
    assign req_prio  = i_s_tdata[psl_pkg::OP_W +: psl_pkg::PRIO_W];
    assign req_value = i_s_tdata[psl_pkg::OP_W + psl_pkg::PRIO_W +: psl_pkg::VAL_W];

    logic r_m_valid;
    logic [psl_pkg::OUT_W-1:0] r_m_data;
    logic [psl_pkg::OUT_W-1:0] n_m_data;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;

    logic accept;
    logic full;
    logic empty;
    assign o_s_tready = !r_m_valid || i_m_tready;
    assign accept     = i_s_tvalid && o_s_tready;
    assign full       = (r_count == CW'(DEPTH));
    assign empty      = (r_count == '0);

    // Command to the chain; refused pushes and empty pops leave it alone
    psl_pkg::t_cell_ctrl ctrl;
    always_comb begin
        ctrl.push  = accept && (req_op == psl_pkg::OP_PUSH) && !full;
        ctrl.pop   = accept && (req_op == psl_pkg::OP_POP) && !empty;
        ctrl.clear = accept && (req_op == psl_pkg::OP_CLEAR);
        ctrl.prio  = req_prio;
        ctrl.value = req_value;
    end

    // Chain of cells, head (highest priority) at index 0
    psl_pkg::t_entry cell_q [DEPTH];
    logic            cell_ge [DEPTH];
    psl_pkg::t_entry blank;
    assign blank = '0;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            psl_pkg::t_entry left_e;
            psl_pkg::t_entry right_e;
            logic            left_ge;
            if (g == 0) begin : g_head
                assign left_e  = blank;
                assign left_ge = 1'b0;
            end else begin : g_mid
                assign left_e  = cell_q[g-1];
                assign left_ge = cell_ge[g-1];
            end
            if (g == DEPTH - 1) begin : g_tail
                assign right_e = blank;
            end else begin : g_body
                assign right_e = cell_q[g+1];
            end
            psl_cell u_cell (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_ctrl    (ctrl),
                .i_left    (left_e),
                .i_left_ge (left_ge),
                .i_right   (right_e),
                .o_entry   (cell_q[g]),
                .o_ge      (cell_ge[g])
            );
        end
    endgenerate

    // Result and count for the accepted request
    logic [psl_pkg::STATUS_W-1:0]     res_status;
    logic signed [psl_pkg::VAL_W-1:0] res_value;
    logic [31:0]                      cnt_ext;
    always_comb begin
        res_status = psl_pkg::ST_DONE;
        res_value  = '0;
        n_count    = r_count;
        case (req_op)
            psl_pkg::OP_PUSH: begin
                if (full) begin
                    res_status = psl_pkg::ST_FULL;
                end else begin
                    n_count = r_count + CW'(1);
                end
            end
            psl_pkg::OP_POP: begin
                if (empty) begin
                    res_status = psl_pkg::ST_EMPTY;
                end else begin
                    res_value = cell_q[0].value;
                    n_count   = r_count - CW'(1);
                end
            end
            psl_pkg::OP_CLEAR: begin
                n_count = '0;
            end
            default: begin
                n_count = r_count;
            end
        endcase
        cnt_ext  = 32'(n_count);
        n_m_data = '0;
        n_m_data[psl_pkg::STATUS_W-1:0] = res_status;
        n_m_data[psl_pkg::STATUS_W +: psl_pkg::VAL_W] = res_value;
        n_m_data[psl_pkg::STATUS_W + psl_pkg::VAL_W +: psl_pkg::CNT_W] =
            cnt_ext[psl_pkg::CNT_W-1:0];
        n_m_data[psl_pkg::OUT_BITS-1] = (n_count == '0);
    end

    // Count and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count   <= n_count;
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
        if (accept) begin
            r_m_data <= n_m_data;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;

endmodule

@@ hdl/psl_cell.sv @@
// One slot of the sorted chain: holds an entry and moves it at most one place on a push or pop.
// Depends on psl_pkg.
module psl_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  psl_pkg::t_cell_ctrl  i_ctrl,
    input  psl_pkg::t_entry      i_left,
    input  logic                 i_left_ge,
    input  psl_pkg::t_entry      i_right,
    output psl_pkg::t_entry      o_entry,
    output logic                 o_ge
);

    psl_pkg::t_entry r_entry;
    psl_pkg::t_entry n_entry;

    // New priority sits at or ahead of this slot: empty slot, or not above
    // the new one (ties go in front, so the newest equal entry leaves first)
    assign o_ge    = !r_entry.valid || (i_ctrl.prio >= r_entry.prio);
    assign o_entry = r_entry;

    // Next contents: emptied on clear, shift right on insert, shift left on removal
    always_comb begin
        n_entry = r_entry;
        if (i_ctrl.clear) begin
            n_entry.valid = 1'b0;
        end else if (i_ctrl.push) begin
            if (i_left_ge) begin
                n_entry = i_left;
            end else if (o_ge) begin
                n_entry.valid = 1'b1;
                n_entry.prio  = i_ctrl.prio;
                n_entry.value = i_ctrl.value;
            end
        end else if (i_ctrl.pop) begin
            n_entry = i_right;
        end
    end

    // Valid bit reset; payload needs none
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry.valid <= 1'b0;
        end else begin
            r_entry.valid <= n_entry.valid;
        end
        r_entry.prio  <= n_entry.prio;
        r_entry.value <= n_entry.value;
    end

endmodule
